@@ design/ternary_packed_dot_accumulate_defines.svh @@
// Assertion macros shared by the ternary dot-product RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TERNARY_PACKED_DOT_ACCUMULATE_DEFINES_SVH
`define TERNARY_PACKED_DOT_ACCUMULATE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TPDA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define TPDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tpda_pkg.sv @@
// Shared widths, register indexes, limits and types for the ternary dot-product block.
// No dependencies.
`default_nettype none

package tpda_pkg;

    localparam int ACT_W   = 8;
    localparam int CODE_W  = 2;
    localparam int LANES   = 4;
    localparam int WB_W    = LANES * CODE_W;
    localparam int PROD_W  = ACT_W + 2;
    localparam int PART_W  = PROD_W + 2;
    localparam int ACC_W   = 22;
    localparam int SCALE_W = 32;
    localparam int BIAS_W  = 32;
    localparam int MUL_W   = ACC_W + SCALE_W + 1;
    localparam int RND_SH  = 8;
    localparam int RND_W   = MUL_W - RND_SH;
    localparam int OUT_W   = 48;
    localparam int SUM_W   = OUT_W + 1;
    localparam int CIDX_W  = 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;

    typedef logic [CIDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_SCALE_FACTOR = 1'b0;
    localparam cfg_index_t REG_BIAS_ENABLE  = 1'b1;

    // Finished row handed from the accumulator to the scaler
    typedef struct packed {
        logic signed [ACC_W-1:0]  sum;
        logic signed [BIAS_W-1:0] bias;
    } row_result_t;

endpackage

`default_nettype wire

@@ design/tpda_lane.sv @@
// One multiply lane: signed activation times a 2-bit-coded weight of -1, 0, 1 or 2, registered.
// Depends on tpda_pkg.
`default_nettype none

module tpda_lane import tpda_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     load,
    input  wire logic signed [ACT_W-1:0]  act,
    input  wire logic [CODE_W-1:0]        code,
    output logic signed [PROD_W-1:0]      prod_reg
);

    // Weight codes: the weight is the code minus one
    localparam logic [CODE_W-1:0] W_NEG  = 2'd0;
    localparam logic [CODE_W-1:0] W_ZERO = 2'd1;
    localparam logic [CODE_W-1:0] W_POS  = 2'd2;
    localparam logic [CODE_W-1:0] W_DBL  = 2'd3;

    logic signed [PROD_W-1:0] act_ext;
    logic signed [PROD_W-1:0] prod_next;

    assign act_ext = {{(PROD_W-ACT_W){act[ACT_W-1]}}, act};

    // Select negate, zero, pass or double
    always_comb
    begin
        unique case (code)
            W_NEG:   prod_next = -act_ext;
            W_ZERO:  prod_next = '0;
            W_POS:   prod_next = act_ext;
            W_DBL:   prod_next = act_ext <<< 1;
            default: prod_next = '0;
        endcase
    end

    // Hold the product until the next item loads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tpda_acc.sv @@
// Merge stage: adds the lane products into the saturating row accumulator
// and hands a finished row to the scaler. Depends on tpda_pkg and the defines header.
`default_nettype none
`include "ternary_packed_dot_accumulate_defines.svh"

module tpda_acc import tpda_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     in_last,
    input  wire logic signed [BIAS_W-1:0] in_bias,
    input  wire logic signed [PROD_W-1:0] lane_prod [LANES],
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output row_result_t                   res
);

    logic                      v1_reg;
    logic                      last1_reg;
    logic signed [BIAS_W-1:0]  bias1_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      v2_reg;
    row_result_t               res_reg;
    logic signed [PART_W-1:0]  part;
    logic signed [ACC_W:0]     total;
    logic signed [ACC_W-1:0]   sat_sum;
    logic                      take1;

    // Merge the lane products
    always_comb
    begin
        part = '0;
        for (int i = 0; i < LANES; i++)
        begin
            part = part + {{(PART_W-PROD_W){lane_prod[i][PROD_W-1]}}, lane_prod[i]};
        end
    end

    // Add into the accumulator and clamp to its range
    assign total = {acc_reg[ACC_W-1], acc_reg}
                 + {{(ACC_W+1-PART_W){part[PART_W-1]}}, part};

    always_comb
    begin
        if (total[ACC_W] != total[ACC_W-1])
        begin
            sat_sum = total[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sat_sum = total[ACC_W-1:0];
        end
    end

    // A row end waits only when the result slot is full and stalled
    assign take1    = v1_reg && (!last1_reg || !v2_reg || res_ready);
    assign in_ready = !v1_reg || take1;
    assign acc_next = last1_reg ? '0 : sat_sum;

    // Stage-one and result-slot control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            acc_reg <= '0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                v1_reg <= 1'b1;
            end
            else if (take1)
            begin
                v1_reg <= 1'b0;
            end

            if (take1)
            begin
                acc_reg <= acc_next;
            end

            if (take1 && last1_reg)
            begin
                v2_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                v2_reg <= 1'b0;
            end
        end
    end

    // Item payload and finished-row payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            last1_reg <= in_last;
            bias1_reg <= in_bias;
        end
        if (take1 && last1_reg)
        begin
            res_reg.sum  <= sat_sum;
            res_reg.bias <= bias1_reg;
        end
    end

    assign res_valid = v2_reg;
    assign res       = res_reg;

    `TPDA_ASSERT_NEXT(a_acc_clear, take1 && last1_reg, acc_reg == '0, "row end did not clear accumulator")
    `TPDA_ASSERT_IMPLY(a_mid_no_stall, v1_reg && !last1_reg, take1, "mid-row item stalled")
    `TPDA_ASSERT_NEXT(a_res_hold, v2_reg && !res_ready, v2_reg && $stable(res_reg), "pending row lost")

endmodule

`default_nettype wire

@@ design/tpda_scale.sv @@
// Output scaler: multiplies the row sum by the Q8.24 scale, rounds to Q.16,
// adds the optional bias and saturates. Depends on tpda_pkg and the defines header.
`default_nettype none
`include "ternary_packed_dot_accumulate_defines.svh"

module tpda_scale import tpda_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [SCALE_W-1:0]       scale_factor,
    input  wire logic                     bias_enable,
    input  wire logic                     res_valid,
    output logic                          res_ready,
    input  wire row_result_t              res,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [ACC_W-1:0]       raw_sum,
    output logic signed [OUT_W-1:0]       scaled_out
);

    logic                      v3_reg;
    logic signed [MUL_W-1:0]   prod_reg;
    logic signed [MUL_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]   sum3_reg;
    logic signed [BIAS_W-1:0]  bias3_reg;
    logic                      out_valid_reg;
    logic signed [ACC_W-1:0]   raw_sum_reg;
    logic signed [OUT_W-1:0]   scaled_reg;
    logic signed [OUT_W-1:0]   scaled_next;
    logic signed [SCALE_W:0]   scale_s;
    logic signed [MUL_W-1:0]   rnd_sum;
    logic signed [RND_W-1:0]   rounded;
    logic signed [SUM_W-1:0]   bias_term;
    logic signed [SUM_W-1:0]   total;
    logic                      ready4;

    assign ready4    = !out_valid_reg || out_ready;
    assign res_ready = !v3_reg || ready4;

    // Multiply stage: signed sum by unsigned scale
    assign scale_s   = {1'b0, scale_factor};
    assign prod_next = res.sum * scale_s;

    // Round half up: add half an LSB, then floor by the shift
    assign rnd_sum   = prod_reg + MUL_W'(1 <<< (RND_SH - 1));
    assign rounded   = rnd_sum[MUL_W-1:RND_SH];
    assign bias_term = bias_enable ? {{(SUM_W-BIAS_W){bias3_reg[BIAS_W-1]}}, bias3_reg}
                                   : '0;
    assign total     = {{(SUM_W-RND_W){rounded[RND_W-1]}}, rounded} + bias_term;

    // Clamp to the output range
    always_comb
    begin
        if (total[SUM_W-1] != total[SUM_W-2])
        begin
            scaled_next = total[SUM_W-1] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            scaled_next = total[OUT_W-1:0];
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_ready)
            begin
                v3_reg <= res_valid;
            end
            if (ready4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            prod_reg  <= prod_next;
            sum3_reg  <= res.sum;
            bias3_reg <= res.bias;
        end
        if (ready4 && v3_reg)
        begin
            raw_sum_reg <= sum3_reg;
            scaled_reg  <= scaled_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign raw_sum    = raw_sum_reg;
    assign scaled_out = scaled_reg;

    `TPDA_ASSERT_NEXT(a_mul_hold, v3_reg && !ready4, v3_reg && $stable(prod_reg), "product lost while stalled")
    `TPDA_ASSERT_NEXT(a_out_load, v3_reg && ready4, out_valid_reg, "product did not reach output")
    `TPDA_ASSERT_NEXT(a_mul_load, res_valid && res_ready, v3_reg, "row not taken into multiply stage")

endmodule

`default_nettype wire

@@ design/ternary_packed_dot_accumulate.sv @@
// Top level of the ternary-weight int8 dot-product accumulator.
// Depends on tpda_pkg, tpda_lane, tpda_acc and tpda_scale.
//
// Input channel (in_valid/in_ready): four signed 8-bit activations, one byte of
// four 2-bit weight codes (weight = code - 1, act_0 pairs with bits 7:6), a
// Q16.16 bias and a last flag. Up to one item is taken per cycle, with no gaps
// between items of a row or between rows while the output keeps up.
// Output channel (out_valid/out_ready): one result per item marked last: the
// saturated 22-bit row sum and the Q32.16 scaled value. The lane registers load
// at the edge that accepts the last item; merge and accumulate, multiply, and
// round/bias/saturate follow, each into its own register, before out_valid
// rises. The 22x33 multiplier product is registered; throughput is one item per
// cycle while no row end is held back.
// Config port: cfg_we writes cfg_data into register cfg_index (0 = scale,
// 1 = bias enable) at once; write only while the block is idle.
// Reset clears the accumulator and all valids, sets the scale to 1.0 and
// disables the bias. When the receiver stalls, results queue in the pipeline
// registers; mid-row items keep flowing, and the input stalls only once a row
// end finds every result slot ahead of it full.
`default_nettype none

module ternary_packed_dot_accumulate import tpda_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CIDX_W-1:0]        cfg_index,
    input  wire logic [SCALE_W-1:0]       cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [ACT_W-1:0]  act_0,
    input  wire logic signed [ACT_W-1:0]  act_1,
    input  wire logic signed [ACT_W-1:0]  act_2,
    input  wire logic signed [ACT_W-1:0]  act_3,
    input  wire logic [WB_W-1:0]          packed_weights,
    input  wire logic signed [BIAS_W-1:0] bias_value,
    input  wire logic                     last,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [ACC_W-1:0]       raw_sum,
    output logic signed [OUT_W-1:0]       scaled_out
);

    logic [SCALE_W-1:0]       scale_factor_reg;
    logic                     bias_enable_reg;
    logic signed [ACT_W-1:0]  act_vec  [LANES];
    logic signed [PROD_W-1:0] lane_prod [LANES];
    logic                     load;
    logic                     res_valid;
    logic                     res_ready;
    row_result_t              res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= SCALE_RESET;
            bias_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE_FACTOR: scale_factor_reg <= cfg_data;
                REG_BIAS_ENABLE:  bias_enable_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign act_vec[0] = act_0;
    assign act_vec[1] = act_1;
    assign act_vec[2] = act_2;
    assign act_vec[3] = act_3;
    assign load       = in_valid && in_ready;

    // Lanes: most significant code pair goes to lane 0
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        tpda_lane u_lane (
            .clk      (clk),
            .load     (load),
            .act      (act_vec[g]),
            .code     (packed_weights[WB_W-1-g*CODE_W -: CODE_W]),
            .prod_reg (lane_prod[g])
        );
    end

    tpda_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_last   (last),
        .in_bias   (bias_value),
        .lane_prod (lane_prod),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    tpda_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale_factor (scale_factor_reg),
        .bias_enable  (bias_enable_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .raw_sum      (raw_sum),
        .scaled_out   (scaled_out)
    );

endmodule

`default_nettype wire
